>>> hdl/dmx_led_bar_decoder_color_mixer_assert.svh
// Assertion macros for the DMX RGBI fixture decoder.
// Included by the top level; no other dependencies.
`ifndef DMX_LED_BAR_DECODER_COLOR_MIXER_ASSERT_SVH
`define DMX_LED_BAR_DECODER_COLOR_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked every cycle outside reset.
`define DMXLBD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the next cycle, outside reset.
`define DMXLBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
// Next-cycle implication that is also checked while reset is applied.
`define DMXLBD_ASSERT_RESET(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`else
`define DMXLBD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define DMXLBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`define DMXLBD_ASSERT_RESET(lbl, clk, ante, cons, msg)
`endif
`endif

>>> hdl/dmxlbd_pkg.sv
// Shared types and constants of the DMX RGBI fixture decoder.
// No dependencies; imported by the top level, dmxlbd_front and dmxlbd_back.
package dmxlbd_pkg;

    localparam int SLOT_W     = 8;
    localparam int LED_W      = 7;
    localparam int START_W    = 9;
    localparam int WR_W       = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_START_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_RATIO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT     = 2'd2;

    localparam logic [START_W-1:0] START_RESET     = 9'd0;
    localparam logic [WR_W-1:0]    WR_RESET        = 9'd128;
    localparam logic [WR_W-1:0]    WR_ONE          = 9'd256;
    localparam logic [LED_W-1:0]   LED_COUNT_RESET = 7'd1;
    localparam logic [SLOT_W-1:0]  DIMMER_RESET    = 8'd255;
    localparam logic [SLOT_W-1:0]  MIX_MAX         = 8'd254;

    // Position of a slot within one LED's group of four.
    typedef enum logic [1:0] {
        LANE_RED       = 2'd0,
        LANE_GREEN     = 2'd1,
        LANE_BLUE      = 2'd2,
        LANE_INTENSITY = 2'd3
    } t_lane;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_byte;
        logic              frame_start;
    } t_slot;

    typedef struct packed {
        logic [LED_W-1:0]  led_index;
        logic [SLOT_W-1:0] red_out;
        logic [SLOT_W-1:0] green_out;
        logic [SLOT_W-1:0] blue_out;
        logic [SLOT_W-1:0] mode_now;
        logic [SLOT_W-1:0] flash_now;
    } t_result;

    // One LED request handed from the slot decoder to the mixer.
    typedef struct packed {
        logic [LED_W-1:0]  led_index;
        logic [SLOT_W-1:0] red;
        logic [SLOT_W-1:0] green;
        logic [SLOT_W-1:0] blue;
        logic [SLOT_W-1:0] intensity;
        logic [SLOT_W-1:0] dimmer;
        logic [SLOT_W-1:0] mode;
        logic [SLOT_W-1:0] flash;
    } t_job;

endpackage

>>> hdl/dmx_led_bar_decoder_color_mixer.sv
// DMX RGBI fixture decoder with white mixing and master dimmer (top level).
// Depends on dmxlbd_pkg, dmxlbd_fifo, dmxlbd_front, dmxlbd_back and the assert header.
//
// Usage: DMX slot bytes are pushed one per request on the input queue
// (push/full, payload i_slot), with frame_start set on slot 0 of a frame.
// The decoder counts slots, skips those before start_channel, captures the
// mode, dimmer and flash slots, then reads red, green, blue and intensity
// for each LED below led_count. Each intensity slot yields one result
// request on the output queue (empty/pop, payload o_result).
// Throughput: one slot per clock, sustained, with pop held high.
// Path: a result is visible (empty low) once its intensity slot has passed
// the request queue, the blend stage, the dimmer stage and the output queue.
// Stall: if pop stays low, the output queue and the two mixer stages fill,
// then the request queue fills and full rises; full depends only on that
// queue, so slots that cause no result are also held off. Nothing is dropped.
// Reset (synchronous, active low) empties all queues, clears the slot count
// and captured values (dimmer to 255) and loads the register defaults.
// Configuration writes (i_cfg_valid/o_cfg_ready) are always accepted and
// must only be issued while the block is idle.
`include "dmx_led_bar_decoder_color_mixer_assert.svh"
module dmx_led_bar_decoder_color_mixer
    import dmxlbd_pkg::*;
#(
    parameter int FRAME_SLOTS = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_slot                 i_slot,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Configuration registers.
    logic [START_W-1:0] r_start_channel;
    logic [WR_W-1:0]    r_white_ratio;
    logic [LED_W-1:0]   r_led_count;

    logic accept;
    logic job_push, mid_full, mid_empty, mid_pop;
    t_job job_in, job_out;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic    res_valid, out_full, out_push;
    t_result res;
    logic [OUT_CNT_W-1:0] out_count;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;
    assign full        = mid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_channel <= START_RESET;
            r_white_ratio   <= WR_RESET;
            r_led_count     <= LED_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_CHANNEL: r_start_channel <= i_cfg_data[START_W-1:0];
                CFG_WHITE_RATIO:   r_white_ratio   <= i_cfg_data[WR_W-1:0];
                CFG_LED_COUNT:     r_led_count     <= i_cfg_data[LED_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: slot counting and capture; issues LED requests.
    dmxlbd_front #(
        .FRAME_SLOTS(FRAME_SLOTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_slot         (i_slot),
        .i_start_channel(r_start_channel),
        .i_led_count    (r_led_count),
        .o_job_push     (job_push),
        .o_job          (job_in)
    );

    // Request queue between the decoder and the mixer.
    dmxlbd_fifo #(
        .WIDTH($bits(t_job)),
        .DEPTH(MID_DEPTH)
    ) u_mid_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_data (job_in),
        .o_full (mid_full),
        .i_pop  (mid_pop),
        .o_data (job_out),
        .o_empty(mid_empty),
        .o_count(mid_count)
    );

    // Back: two-stage blend and dimmer pipeline.
    dmxlbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (!mid_empty),
        .i_job        (job_out),
        .o_job_pop    (mid_pop),
        .i_white_ratio(r_white_ratio),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (!out_full)
    );

    assign out_push = res_valid && !out_full;

    // Output queue; its head drives the result ports.
    dmxlbd_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(OUT_DEPTH)
    ) u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_data (res),
        .o_full (out_full),
        .i_pop  (pop),
        .o_data (o_result),
        .o_empty(empty),
        .o_count(out_count)
    );

    // A request is only queued when the queue has room, which full guarantees.
    `DMXLBD_ASSERT_IMPL(a_mid_no_overflow, i_clk, i_rst_n, job_push, !mid_full || mid_count == '0, "request queue overflow")
    // Popping the last result with nothing arriving leaves the queue empty.
    `DMXLBD_ASSERT_NEXT(a_last_pop_empties, i_clk, i_rst_n, pop && !empty && !out_push && out_count == OUT_CNT_W'(1), empty, "output queue did not drain")
    // Reset leaves no result pending and the input open.
    `DMXLBD_ASSERT_RESET(a_reset_clears, i_clk, !i_rst_n, empty && !full, "queues not cleared by reset")

endmodule

>>> hdl/dmxlbd_fifo.sv
// Small register queue with registered pointers and an occupancy count.
// Depends on nothing; used between the decoder stages and at the output.
module dmxlbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hdl/dmxlbd_front.sv
// Slot decoder: counts slots in the frame, captures header and colour slots,
// and issues one LED request per intensity slot. Depends on dmxlbd_pkg.
module dmxlbd_front
    import dmxlbd_pkg::*;
#(
    parameter int FRAME_SLOTS = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_slot              i_slot,
    input  logic [START_W-1:0] i_start_channel,
    input  logic [LED_W-1:0]   i_led_count,
    output logic               o_job_push,
    output t_job               o_job
);

    localparam int PW    = $clog2(FRAME_SLOTS + 1);
    localparam int CMP_W = (PW > START_W) ? PW : START_W;
    localparam logic [START_W-1:0] REL_MODE   = START_W'(0);
    localparam logic [START_W-1:0] REL_DIMMER = START_W'(1);
    localparam logic [START_W-1:0] REL_FLASH  = START_W'(2);
    localparam logic [START_W-1:0] REL_FIRST  = START_W'(3);

    logic [PW-1:0]     r_slot_counter;
    logic [SLOT_W-1:0] r_mode, r_dimmer, r_flash;
    logic [SLOT_W-1:0] r_held_red, r_held_green, r_held_blue;

    logic [PW-1:0]      pos;
    logic               in_frame, after_start, led_ok, take;
    logic [CMP_W-1:0]   diff;
    logic [START_W-1:0] rel, rel_m3;
    logic [LED_W-1:0]   led;
    t_lane              lane;

    always_comb begin
        pos         = i_slot.frame_start ? '0 : r_slot_counter;
        in_frame    = (pos < PW'(FRAME_SLOTS));
        after_start = (CMP_W'(pos) >= CMP_W'(i_start_channel));
        diff        = CMP_W'(pos) - CMP_W'(i_start_channel);
        rel         = diff[START_W-1:0];
        rel_m3      = rel - REL_FIRST;
        led         = rel_m3[START_W-1:2];
        lane        = t_lane'(rel_m3[1:0]);
        led_ok      = (led < i_led_count);
        take        = i_accept && in_frame && after_start;
    end

    assign o_job_push = take && (rel >= REL_FIRST) && led_ok && (lane == LANE_INTENSITY);

    always_comb begin
        o_job.led_index = led;
        o_job.red       = r_held_red;
        o_job.green     = r_held_green;
        o_job.blue      = r_held_blue;
        o_job.intensity = i_slot.slot_byte;
        o_job.dimmer    = r_dimmer;
        o_job.mode      = r_mode;
        o_job.flash     = r_flash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_counter <= '0;
            r_mode         <= '0;
            r_dimmer       <= DIMMER_RESET;
            r_flash        <= '0;
            r_held_red     <= '0;
            r_held_green   <= '0;
            r_held_blue    <= '0;
        end else begin
            if (i_accept) begin
                // The counter parks at the frame length until the next frame start.
                r_slot_counter <= in_frame ? pos + 1'b1 : PW'(FRAME_SLOTS);
            end
            if (take) begin
                case (rel)
                    REL_MODE:   r_mode   <= i_slot.slot_byte;
                    REL_DIMMER: r_dimmer <= i_slot.slot_byte;
                    REL_FLASH:  r_flash  <= i_slot.slot_byte;
                    default: begin
                        if (led_ok) begin
                            case (lane)
                                LANE_RED:   r_held_red   <= i_slot.slot_byte;
                                LANE_GREEN: r_held_green <= i_slot.slot_byte;
                                LANE_BLUE:  r_held_blue  <= i_slot.slot_byte;
                                default: ;
                            endcase
                        end
                    end
                endcase
            end
        end
    end

endmodule

>>> hdl/dmxlbd_back.sv
// Colour mixer: white blend with clamp in the first stage, master dimmer
// scaling by dimmer/255 in the second. Depends on dmxlbd_pkg.
module dmxlbd_back
    import dmxlbd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  t_job            i_job,
    output logic            o_job_pop,
    input  logic [WR_W-1:0] i_white_ratio,
    output logic            o_res_valid,
    output t_result         o_res,
    input  logic            i_res_ready
);

    typedef struct packed {
        logic [LED_W-1:0]  led_index;
        logic [SLOT_W-1:0] red;
        logic [SLOT_W-1:0] green;
        logic [SLOT_W-1:0] blue;
        logic [SLOT_W-1:0] dimmer;
        logic [SLOT_W-1:0] mode;
        logic [SLOT_W-1:0] flash;
    } t_mixed;

    // (intensity*(256-w) + colour*w) >> 8, limited to 254.
    function automatic logic [SLOT_W-1:0] mix(input logic [SLOT_W-1:0] c,
                                             input logic [SLOT_W-1:0] i,
                                             input logic [WR_W-1:0]   w,
                                             input logic [WR_W-1:0]   inv);
        logic [16:0] s;
        s = 17'(i) * 17'(inv) + 17'(c) * 17'(w);
        if (s[16:8] > 9'(MIX_MAX)) begin
            return MIX_MAX;
        end
        return s[15:8];
    endfunction

    // floor(m*d/255); the added high byte and one make the shift exact here.
    function automatic logic [SLOT_W-1:0] dim(input logic [SLOT_W-1:0] m,
                                             input logic [SLOT_W-1:0] d);
        logic [15:0] x;
        logic [16:0] t;
        x = 16'(m) * 16'(d);
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    logic            r_s1_valid, r_s2_valid;
    t_mixed          r_s1;
    t_result         r_s2;
    logic            s1_ready, s2_ready;
    logic [WR_W-1:0] w_eff, w_inv;

    assign w_eff     = (i_white_ratio > WR_ONE) ? WR_ONE : i_white_ratio;
    assign w_inv     = WR_ONE - w_eff;
    assign s2_ready  = !r_s2_valid || i_res_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;
    assign o_job_pop = i_job_valid && s1_ready;
    assign o_res_valid = r_s2_valid;
    assign o_res       = r_s2;

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_s1.led_index <= i_job.led_index;
            r_s1.red       <= mix(i_job.red, i_job.intensity, w_eff, w_inv);
            r_s1.green     <= mix(i_job.green, i_job.intensity, w_eff, w_inv);
            r_s1.blue      <= mix(i_job.blue, i_job.intensity, w_eff, w_inv);
            r_s1.dimmer    <= i_job.dimmer;
            r_s1.mode      <= i_job.mode;
            r_s1.flash     <= i_job.flash;
        end
        if (r_s1_valid && s2_ready) begin
            r_s2.led_index <= r_s1.led_index;
            r_s2.red_out   <= dim(r_s1.red, r_s1.dimmer);
            r_s2.green_out <= dim(r_s1.green, r_s1.dimmer);
            r_s2.blue_out  <= dim(r_s1.blue, r_s1.dimmer);
            r_s2.mode_now  <= r_s1.mode;
            r_s2.flash_now <= r_s1.flash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_job_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

endmodule
